// ----- sv/rsp_pkg.sv -----
`default_nettype none
package rsp_pkg;

  localparam int TABLE_DEPTH  = 16;
  localparam int CELL_BITS    = 8;
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 24;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W = 2 * CELL_BITS;

  // datapath widths
  localparam int DXW    = CELL_BITS + FRAC_BITS + 3;
  localparam int XW     = 48;
  localparam int ZW     = 28;
  localparam int STEP_W = 5;
  localparam int SQ_W   = 50;
  localparam int LEN_W  = SQ_W / 2 + 1;
  localparam int NUM_W  = 52;
  localparam int DEN_W  = 50;
  localparam int Q_W    = 16;

  localparam logic signed [ZW-1:0] DEG90  = ZW'(90 << FRAC_BITS);
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 << FRAC_BITS);
  localparam logic signed [ZW-1:0] DEG360 = ZW'(360 << FRAC_BITS);
  localparam logic signed [XW-1:0] KINV   = XW'(652032874);

  localparam int HEIGHT_SAT = 65535;
  localparam int DIST_SAT   = 33554432;

  typedef enum logic [1:0] {
    ST_INSERT = 2'd0,
    ST_UPDATE = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_SCREEN_HEIGHT = 2'd0,
    CFG_VIEW_ANGLE    = 2'd1
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SEARCH, S_SQ1, S_SQ2, S_VEC, S_VEC_WAIT, S_WRAP1, S_WRAP2,
    S_ROT1, S_ROT1_WAIT, S_MUL1, S_MUL2, S_PERP, S_ROT2, S_ROT2_WAIT,
    S_NUM, S_DEN, S_DIV, S_DIV_WAIT, S_FIN, S_DONE
  } state_t;

  // atan(2^-i) in degrees, scaled to FRAC_BITS fraction bits
  function automatic logic signed [ZW-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic [31:0] q24;
    case (i)
      5'd0:  q24 = 32'd754974720;
      5'd1:  q24 = 32'd445687602;
      5'd2:  q24 = 32'd235489089;
      5'd3:  q24 = 32'd119537938;
      5'd4:  q24 = 32'd60000934;
      5'd5:  q24 = 32'd30029717;
      5'd6:  q24 = 32'd15018523;
      5'd7:  q24 = 32'd7509720;
      5'd8:  q24 = 32'd3754917;
      5'd9:  q24 = 32'd1877466;
      5'd10: q24 = 32'd938734;
      5'd11: q24 = 32'd469367;
      5'd12: q24 = 32'd234685;
      5'd13: q24 = 32'd117343;
      5'd14: q24 = 32'd58671;
      5'd15: q24 = 32'd29336;
      5'd16: q24 = 32'd14668;
      5'd17: q24 = 32'd7334;
      5'd18: q24 = 32'd3667;
      5'd19: q24 = 32'd1833;
      5'd20: q24 = 32'd917;
      5'd21: q24 = 32'd458;
      5'd22: q24 = 32'd229;
      5'd23: q24 = 32'd115;
      default: q24 = 32'd0;
    endcase
    return ZW'(q24 >> (24 - FRAC_BITS));
  endfunction

endpackage
`default_nettype wire

// ----- sv/rsp_cordic.sv -----
`default_nettype none
module rsp_cordic (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            vec_mode,
  input  logic signed [rsp_pkg::XW-1:0]   x0,
  input  logic signed [rsp_pkg::XW-1:0]   y0,
  input  logic signed [rsp_pkg::ZW-1:0]   z0,
  output logic                            busy,
  output logic signed [rsp_pkg::XW-1:0]   x_out,
  output logic signed [rsp_pkg::XW-1:0]   y_out,
  output logic signed [rsp_pkg::ZW-1:0]   z_out
);
  import rsp_pkg::*;

  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [ZW-1:0] z_r, z_nxt, a;
  logic [STEP_W-1:0]    step_r;
  logic                 busy_r, mode_r, dir;

  always_comb begin
    xs = x_r >>> step_r;
    ys = y_r >>> step_r;
    a  = atan_step(step_r);
    // vectoring drives y to zero, rotation drives z to zero
    dir = mode_r ? ~y_r[XW-1] : z_r[ZW-1];
    if (dir) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + a;
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && step_r == STEP_W'(CORDIC_STEPS - 1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x0;
      y_r    <= y0;
      z_r    <= z0;
      mode_r <= vec_mode;
      step_r <= '0;
    end else if (busy_r) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      step_r <= step_r + 1'b1;
    end
  end

  assign busy  = busy_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule
`default_nettype wire

// ----- sv/rsp_isqrt.sv -----
`default_nettype none
module rsp_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rsp_pkg::SQ_W-1:0]    v_in,
  output logic                        busy,
  output logic [rsp_pkg::LEN_W-1:0]   root
);
  import rsp_pkg::*;

  logic [SQ_W-1:0] v_r, r_r, bit_r, v_nxt, r_nxt;
  logic [SQ_W:0]   trial;
  logic            busy_r;

  always_comb begin
    trial = {1'b0, r_r} + {1'b0, bit_r};
    if ({1'b0, v_r} >= trial) begin
      v_nxt = v_r - trial[SQ_W-1:0];
      r_nxt = (r_r >> 1) + bit_r;
    end else begin
      v_nxt = v_r;
      r_nxt = r_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && bit_r[0]) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= v_in;
      r_r   <= '0;
      bit_r <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_r) begin
      v_r   <= v_nxt;
      r_r   <= r_nxt;
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign root = r_r[LEN_W-1:0];

endmodule
`default_nettype wire

// ----- sv/rsp_div.sv -----
`default_nettype none
module rsp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rsp_pkg::NUM_W-1:0]   num_mag,
  input  logic [rsp_pkg::DEN_W-1:0]   den_mag,
  output logic                        busy,
  output logic                        sat,
  output logic [rsp_pkg::Q_W-1:0]     quo
);
  import rsp_pkg::*;

  localparam int DW = DEN_W + Q_W + 1;
  localparam int CW = $clog2(Q_W);

  logic [DW-1:0]      rem_r, dsh_r;
  logic [Q_W-1:0]     q_r;
  logic [CW-1:0]      cnt_r;
  logic               busy_r, sat_r, ge;

  assign ge = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == CW'(Q_W - 1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DW'(num_mag);
      dsh_r <= DW'(den_mag) << (Q_W - 1);
      // quotient too large for the result width
      sat_r <= DW'(num_mag) >= (DW'(den_mag) << Q_W);
      q_r   <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[Q_W-2:0], ge};
      dsh_r <= dsh_r >> 1;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign busy = busy_r;
  assign sat  = sat_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

// ----- sv/raycast_sprite_register_project.sv -----
`default_nettype none
// an update or a full table goes from the search straight to the final state and the output;
// the divider is skipped when the distance is not positive or the divisor is zero
// new sprite: cordic atan2 (24 steps) beside the square root (25 steps), then two
// cordic sin/cos runs of 24 steps and a 16-step divider, each with its setup states
// the block takes one item at a time; a stalled result holds
// the block; reset: sprite table empty, screen_height 480, view_angle 66 degrees
module raycast_sprite_register_project (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_new_frame,
  input  logic [11:0]        in_column,
  input  logic [7:0]         in_cell_x,
  input  logic [7:0]         in_cell_y,
  input  logic [5:0]         in_cell_char,
  input  logic [24:0]        in_player_x,
  input  logic [24:0]        in_player_y,
  input  logic [24:0]        in_player_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [3:0]         out_entry_index,
  output logic [11:0]        out_start_column,
  output logic [11:0]        out_end_column,
  output logic [2:0]         out_sprite_texture,
  output logic signed [26:0] out_sprite_angle,
  output logic signed [26:0] out_perp_distance,
  output logic signed [16:0] out_line_height,
  output logic signed [17:0] out_draw_start_y,
  output logic signed [17:0] out_draw_end_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import rsp_pkg::*;

  state_t state_r, state_nxt;

  // config
  logic [11:0] h_r;
  logic [23:0] view_r;

  // item
  logic [11:0]          col_r;
  logic [CELL_BITS-1:0] cx_r, cy_r;
  logic [2:0]           tex_r;
  logic [24:0]          px_r, py_r, pa_r;

  // table
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [KEY_W-1:0]       cell_r [TABLE_DEPTH];
  logic [11:0]            start_col_r [TABLE_DEPTH];
  logic [CNT_W-1:0]       count_r;
  logic [KEY_W-1:0]       key;
  logic                   hit, full;
  logic [IDX_W-1:0]       hit_idx;

  // work registers
  status_t                 status_r;
  logic [IDX_W-1:0]        idx_r;
  logic [11:0]             start_out_r;
  logic signed [DXW-1:0]   dx_r, dy_r, mul_a, dx_c, dy_c;
  logic signed [2*DXW-1:0] sqp;
  logic [SQ_W-1:0]         sq_r;
  logic                    zero_r, back_r, neg_r;
  logic [LEN_W-1:0]        len_r;
  logic signed [ZW-1:0]    ang_r, wrap_t, diff, absd, vh, rot_d;
  logic signed [32:0]      c_r, c_full;
  logic signed [59:0]      prod_r, perp_t;
  logic signed [LEN_W+16:0] mh;
  logic signed [26:0]      perp_r;
  logic signed [22:0]      vc_r, vs_r;
  logic signed [35:0]      hv;
  logic signed [NUM_W-1:0] num_r;
  logic signed [DEN_W-1:0] den_r;
  logic signed [16:0]      lh_r, half_lh, lh_mag;
  logic signed [17:0]      ds_r, de_r;
  logic [10:0]             hh;

  // shared units
  logic                  cor_start, cor_vec, cor_busy, sq_start, sq_busy;
  logic                  div_start, div_busy, div_sat;
  logic signed [XW-1:0]  cx0, cy0, cor_x, cor_y, xv, yv;
  logic signed [ZW-1:0]  cz0, cor_z;
  logic [LEN_W-1:0]      root;
  logic [Q_W-1:0]        quo;
  logic [NUM_W-1:0]      num_mag;
  logic [DEN_W-1:0]      den_mag;

  // output register
  logic        out_valid_r;
  logic [1:0]  o_status_r;
  logic [3:0]  o_idx_r;
  logic [11:0] o_start_r, o_end_r;
  logic [2:0]  o_tex_r;
  logic signed [26:0] o_ang_r, o_perp_r;
  logic signed [16:0] o_lh_r;
  logic signed [17:0] o_ds_r, o_de_r;
  logic        accept, load_out;

  rsp_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .vec_mode(cor_vec),
    .x0(cx0), .y0(cy0), .z0(cz0), .busy(cor_busy),
    .x_out(cor_x), .y_out(cor_y), .z_out(cor_z)
  );

  rsp_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .v_in(sq_r),
    .busy(sq_busy), .root(root)
  );

  rsp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num_mag(num_mag),
    .den_mag(den_mag), .busy(div_busy), .sat(div_sat), .quo(quo)
  );

  // table search, entries compared side by side
  always_comb begin
    key     = {cy_r, cx_r};
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (valid_r[i] && cell_r[i] == key) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
    full = count_r >= CNT_W'(TABLE_DEPTH);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_SEARCH;
      S_SEARCH:    state_nxt = (hit || full) ? S_FIN : S_SQ1;
      S_SQ1:       state_nxt = S_SQ2;
      S_SQ2:       state_nxt = S_VEC;
      S_VEC:       state_nxt = S_VEC_WAIT;
      S_VEC_WAIT:  if (!cor_busy && !sq_busy) state_nxt = S_WRAP1;
      S_WRAP1:     state_nxt = S_WRAP2;
      S_WRAP2:     state_nxt = S_ROT1;
      S_ROT1:      state_nxt = S_ROT1_WAIT;
      S_ROT1_WAIT: if (!cor_busy) state_nxt = S_MUL1;
      S_MUL1:      state_nxt = S_MUL2;
      S_MUL2:      state_nxt = S_PERP;
      S_PERP:      state_nxt = S_ROT2;
      S_ROT2:      state_nxt = S_ROT2_WAIT;
      S_ROT2_WAIT: if (!cor_busy) state_nxt = S_NUM;
      S_NUM:       state_nxt = S_DEN;
      S_DEN:       state_nxt = S_DIV;
      S_DIV:       state_nxt = (perp_r <= 0 || den_r == '0) ? S_FIN : S_DIV_WAIT;
      S_DIV_WAIT:  if (!div_busy) state_nxt = S_FIN;
      S_FIN:       state_nxt = S_DONE;
      S_DONE:      if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = state_r != S_IDLE;
    cor_start = state_r == S_VEC || state_r == S_ROT1 || state_r == S_ROT2;
    cor_vec   = state_r == S_VEC;
    sq_start  = state_r == S_VEC;
    div_start = state_r == S_DIV && !(perp_r <= 0 || den_r == '0);
    load_out  = state_r == S_DONE && (!out_valid_r || !out_stall);
    cfg_ready = 1'b1;
  end

  assign accept = in_valid && state_r == S_IDLE;

  // datapath helpers
  always_comb begin
    dx_c = $signed(DXW'({cx_r, FRAC_BITS'(0)}) + DXW'(1 << (FRAC_BITS - 1))
                   - DXW'(px_r));
    dy_c = $signed(DXW'(py_r) - DXW'({cy_r, FRAC_BITS'(0)})
                   - DXW'(1 << (FRAC_BITS - 1)));
    mul_a = (state_r == S_SQ1) ? dx_r : dy_r;
    sqp   = mul_a * mul_a;

    xv = XW'(dx_r) <<< 20;
    yv = XW'(dy_r) <<< 20;

    wrap_t = ang_r - $signed(ZW'(pa_r));
    diff   = $signed(ZW'(pa_r)) - ang_r;
    absd   = diff[ZW-1] ? -diff : diff;
    vh     = $signed(ZW'(view_r >> 1));
    if (vh > DEG180) vh = DEG180;
    rot_d  = (state_r == S_ROT1) ? absd : vh;

    // quadrant fold before vectoring, angle fold before rotation
    if (state_r == S_VEC) begin
      if (xv[XW-1]) begin
        if (!yv[XW-1]) begin
          cx0 = yv;  cy0 = -xv; cz0 = DEG90;
        end else begin
          cx0 = -yv; cy0 = xv;  cz0 = -DEG90;
        end
      end else begin
        cx0 = xv; cy0 = yv; cz0 = '0;
      end
    end else begin
      cx0 = KINV;
      cy0 = '0;
      cz0 = (rot_d > DEG90) ? DEG180 - rot_d : rot_d;
    end

    c_full = back_r ? -cor_x[32:0] : cor_x[32:0];
    mh     = $signed({1'b0, len_r}) * $signed(c_r[32:16]);
    perp_t = prod_r >>> 30;
    hv     = $signed({1'b0, h_r}) * vc_r;

    num_mag = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
    den_mag = den_r[DEN_W-1] ? DEN_W'(-den_r) : DEN_W'(den_r);

    lh_mag  = div_sat ? 17'(HEIGHT_SAT) : $signed({1'b0, quo});
    half_lh = (lh_r + $signed({16'd0, lh_r[16]})) >>> 1;
    hh      = h_r[11:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // config and table control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r     <= 12'd480;
      view_r  <= 24'd4325376;
      valid_r <= '0;
      count_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SCREEN_HEIGHT: h_r    <= cfg_data[11:0];
          CFG_VIEW_ANGLE:    view_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept && in_new_frame) begin
        valid_r <= '0;
        count_r <= '0;
      end else if (state_r == S_SEARCH && !hit && !full) begin
        valid_r[count_r[IDX_W-1:0]] <= 1'b1;
        count_r <= count_r + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      col_r <= in_column;
      cx_r  <= CELL_BITS'(in_cell_x);
      cy_r  <= CELL_BITS'(in_cell_y);
      tex_r <= in_cell_char[2:0] - 3'd2;
      px_r  <= in_player_x;
      py_r  <= in_player_y;
      pa_r  <= in_player_angle;
    end
    unique case (state_r)
      S_SEARCH: begin
        if (hit) begin
          status_r    <= ST_UPDATE;
          idx_r       <= hit_idx;
          start_out_r <= start_col_r[hit_idx];
        end else if (full) begin
          status_r <= ST_FULL;
        end else begin
          status_r    <= ST_INSERT;
          idx_r       <= count_r[IDX_W-1:0];
          start_out_r <= col_r;
          cell_r[count_r[IDX_W-1:0]]      <= key;
          start_col_r[count_r[IDX_W-1:0]] <= col_r;
          dx_r <= dx_c;
          dy_r <= dy_c;
        end
        lh_r <= '0;
      end
      S_SQ1: sq_r <= sqp[SQ_W-1:0];
      S_SQ2: begin
        sq_r   <= sq_r + sqp[SQ_W-1:0];
        zero_r <= dx_r == '0 && dy_r == '0;
      end
      S_VEC_WAIT: begin
        ang_r <= zero_r ? '0 : cor_z;
        len_r <= root;
      end
      S_WRAP1: if (ang_r[ZW-1]) ang_r <= ang_r + DEG360;
      S_WRAP2: begin
        if (wrap_t > DEG180) ang_r <= ang_r - DEG360;
        else if (wrap_t < -DEG180) ang_r <= ang_r + DEG360;
      end
      S_ROT1, S_ROT2: back_r <= rot_d > DEG90;
      S_ROT1_WAIT: c_r <= c_full;
      S_MUL1: prod_r <= 60'(len_r * c_r[15:0]);
      S_MUL2: prod_r <= prod_r + (60'(mh) <<< 16);
      S_PERP: begin
        if (perp_t > 60'(DIST_SAT)) perp_r <= 27'(DIST_SAT);
        else if (perp_t < -60'(DIST_SAT)) perp_r <= -27'(DIST_SAT);
        else perp_r <= perp_t[26:0];
      end
      S_ROT2_WAIT: begin
        vc_r <= c_full[32:10];
        vs_r <= cor_y[32:10];
      end
      S_NUM: num_r <= NUM_W'(hv) <<< FRAC_BITS;
      S_DEN: den_r <= perp_r * vs_r;
      S_DIV: begin
        neg_r <= num_r[NUM_W-1] ^ den_r[DEN_W-1];
        if (perp_r <= 0) lh_r <= 17'(HEIGHT_SAT);
        else if (den_r == '0) lh_r <= vc_r[22] ? -17'(HEIGHT_SAT) : 17'(HEIGHT_SAT);
      end
      S_DIV_WAIT: if (!div_busy) lh_r <= neg_r ? -lh_mag : lh_mag;
      S_FIN: begin
        ds_r <= $signed({7'd0, hh}) - 18'(half_lh);
        de_r <= $signed({7'd0, hh}) + 18'(half_lh);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_status_r <= status_r;
      o_idx_r    <= (status_r == ST_FULL) ? 4'd0 : 4'(idx_r);
      o_start_r  <= (status_r == ST_FULL) ? 12'd0 : start_out_r;
      o_end_r    <= (status_r == ST_FULL) ? 12'd0 : col_r;
      o_tex_r    <= (status_r == ST_FULL) ? 3'd0 : tex_r;
      if (status_r == ST_INSERT) begin
        o_ang_r  <= ang_r[26:0];
        o_perp_r <= perp_r;
        o_lh_r   <= lh_r;
        o_ds_r   <= ds_r;
        o_de_r   <= de_r;
      end else begin
        o_ang_r  <= '0;
        o_perp_r <= '0;
        o_lh_r   <= '0;
        o_ds_r   <= '0;
        o_de_r   <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_entry_index    = o_idx_r;
  assign out_start_column   = o_start_r;
  assign out_end_column     = o_end_r;
  assign out_sprite_texture = o_tex_r;
  assign out_sprite_angle   = o_ang_r;
  assign out_perp_distance  = o_perp_r;
  assign out_line_height    = o_lh_r;
  assign out_draw_start_y   = o_ds_r;
  assign out_draw_end_y     = o_de_r;

endmodule
`default_nettype wire
